@@ sv/pcm_pkg.sv @@
// Package for the PWM capture monitor: types, command codes and constants.
package pcm_pkg;

  typedef logic [15:0] word_t;
  typedef logic [7:0]  count_t;
  typedef logic [1:0]  cmd_code_t;

  typedef enum logic [1:0] {
    CMD_CAPTURE = 2'd0,
    CMD_TICK    = 2'd1,
    CMD_CLEAR   = 2'd2
  } cmd_t;

  localparam word_t  MASK15           = 16'h7FFF;
  localparam word_t  DEAD_WORD        = 16'h8000;
  localparam word_t  WORD_MAX         = 16'hFFFF;
  localparam word_t  WORD_ONE         = 16'h0001;
  localparam count_t COUNT_ONE        = 8'd1;
  localparam count_t DEAD_COUNT_RESET = 8'd5;

  typedef struct packed {
    cmd_code_t cmd;
    word_t     period_us;
    word_t     width_us;
    word_t     capture_status;
    logic      live_level;
  } item_t;

  typedef struct packed {
    logic  report_valid;
    word_t period_report;
    word_t width_report;
    logic  dead_flag;
    word_t capture_total;
    word_t least_period;
    word_t greatest_period;
    word_t least_width;
    word_t greatest_width;
    word_t stored_status;
  } result_t;

endpackage

@@ sv/pcm_if.sv @@
// Channel interfaces of the PWM capture monitor: input items, results, config writes.
interface pcm_in_if;
  logic              valid;
  logic              ready;
  pcm_pkg::cmd_code_t cmd;
  pcm_pkg::word_t    period_us;
  pcm_pkg::word_t    width_us;
  pcm_pkg::word_t    capture_status;
  logic              live_level;

  modport source (output valid, cmd, period_us, width_us, capture_status, live_level,
                  input ready);
  modport sink   (input valid, cmd, period_us, width_us, capture_status, live_level,
                  output ready);
endinterface

interface pcm_out_if;
  logic           valid;
  logic           ready;
  logic           report_valid;
  pcm_pkg::word_t period_report;
  pcm_pkg::word_t width_report;
  logic           dead_flag;
  pcm_pkg::word_t capture_total;
  pcm_pkg::word_t least_period;
  pcm_pkg::word_t greatest_period;
  pcm_pkg::word_t least_width;
  pcm_pkg::word_t greatest_width;
  pcm_pkg::word_t stored_status;

  modport source (output valid, report_valid, period_report, width_report, dead_flag,
                  capture_total, least_period, greatest_period, least_width,
                  greatest_width, stored_status,
                  input ready);
  modport sink   (input valid, report_valid, period_report, width_report, dead_flag,
                  capture_total, least_period, greatest_period, least_width,
                  greatest_width, stored_status,
                  output ready);
endinterface

interface pcm_cfg_if;
  logic            valid;
  logic            ready;
  pcm_pkg::count_t max_dead_count;

  modport source (output valid, max_dead_count, input ready);
  modport sink   (input valid, max_dead_count, output ready);
endinterface

@@ sv/pcm_in_reg.sv @@
// Input register: captures one item per transfer and holds it until the engine takes it.
module pcm_in_reg (
  input  logic           clk,
  input  logic           rst,
  pcm_in_if.sink         item,
  input  logic           take,
  output logic           held_valid,
  output pcm_pkg::item_t held
);
  import pcm_pkg::*;

  logic accept;

  assign item.ready = !held_valid || take;
  assign accept     = item.valid && item.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held.cmd            <= item.cmd;
      held.period_us      <= item.period_us;
      held.width_us       <= item.width_us;
      held.capture_status <= item.capture_status;
      held.live_level     <= item.live_level;
    end
  end

endmodule

@@ sv/pcm_engine.sv @@
// Monitor state, per-item update logic and the result register.
module pcm_engine (
  input  logic            clk,
  input  logic            rst,
  input  logic            held_valid,
  input  pcm_pkg::item_t  held,
  input  pcm_pkg::count_t max_dead_count,
  output logic            take,
  pcm_out_if.source       result
);
  import pcm_pkg::*;

  word_t  held_period, held_period_next;
  word_t  held_width, held_width_next;
  word_t  held_status, held_status_next;
  word_t  capture_counter, capture_counter_next;
  word_t  counter_at_last_tick, counter_at_last_tick_next;
  count_t idle_ticks, idle_ticks_next;
  logic   dead_mark, dead_mark_next;
  word_t  period_low_mark, period_low_mark_next;
  word_t  period_high_mark, period_high_mark_next;
  word_t  width_low_mark, width_low_mark_next;
  word_t  width_high_mark, width_high_mark_next;

  logic    out_valid;
  result_t res, res_next;
  count_t  idle_inc;

  assign take     = held_valid && (!out_valid || result.ready);
  assign idle_inc = idle_ticks + COUNT_ONE;

  always_comb begin
    held_period_next          = held_period;
    held_width_next           = held_width;
    held_status_next          = held_status;
    capture_counter_next      = capture_counter;
    counter_at_last_tick_next = counter_at_last_tick;
    idle_ticks_next           = idle_ticks;
    dead_mark_next            = dead_mark;
    period_low_mark_next      = period_low_mark;
    period_high_mark_next     = period_high_mark;
    width_low_mark_next       = width_low_mark;
    width_high_mark_next      = width_high_mark;
    res_next                  = '0;

    case (held.cmd)
      CMD_CAPTURE: begin
        held_period_next     = held.period_us;
        held_width_next      = held.width_us;
        held_status_next     = held.capture_status;
        if (held.period_us > period_high_mark) period_high_mark_next = held.period_us;
        if (held.period_us < period_low_mark)  period_low_mark_next  = held.period_us;
        if (held.width_us > width_high_mark)   width_high_mark_next  = held.width_us;
        if (held.width_us < width_low_mark)    width_low_mark_next   = held.width_us;
        capture_counter_next = capture_counter + WORD_ONE;
      end
      CMD_TICK: begin
        if (counter_at_last_tick == capture_counter) begin
          if (idle_ticks < max_dead_count) begin
            idle_ticks_next = idle_inc;
            if (idle_inc >= max_dead_count) dead_mark_next = 1'b1;
          end
        end else begin
          dead_mark_next  = 1'b0;
          idle_ticks_next = '0;
        end
        counter_at_last_tick_next = capture_counter;
        res_next.report_valid     = 1'b1;
        if (!dead_mark_next) begin
          res_next.period_report = held_period & MASK15;
          res_next.width_report  = held_width & MASK15;
        end else begin
          res_next.period_report = DEAD_WORD;
          res_next.width_report  = held.live_level ? DEAD_WORD : '0;
        end
      end
      CMD_CLEAR: begin
        period_low_mark_next  = WORD_MAX;
        period_high_mark_next = '0;
        width_low_mark_next   = WORD_MAX;
        width_high_mark_next  = '0;
      end
      default: begin
        // unused code: no state change
      end
    endcase

    res_next.dead_flag       = dead_mark_next;
    res_next.capture_total   = capture_counter_next;
    res_next.least_period    = period_low_mark_next;
    res_next.greatest_period = period_high_mark_next;
    res_next.least_width     = width_low_mark_next;
    res_next.greatest_width  = width_high_mark_next;
    res_next.stored_status   = held_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_period          <= '0;
      held_width           <= '0;
      held_status          <= '0;
      capture_counter      <= '0;
      counter_at_last_tick <= '0;
      idle_ticks           <= '0;
      dead_mark            <= 1'b1;
      period_low_mark      <= WORD_MAX;
      period_high_mark     <= '0;
      width_low_mark       <= WORD_MAX;
      width_high_mark      <= '0;
    end else if (take) begin
      held_period          <= held_period_next;
      held_width           <= held_width_next;
      held_status          <= held_status_next;
      capture_counter      <= capture_counter_next;
      counter_at_last_tick <= counter_at_last_tick_next;
      idle_ticks           <= idle_ticks_next;
      dead_mark            <= dead_mark_next;
      period_low_mark      <= period_low_mark_next;
      period_high_mark     <= period_high_mark_next;
      width_low_mark       <= width_low_mark_next;
      width_high_mark      <= width_high_mark_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign result.valid           = out_valid;
  assign result.report_valid    = res.report_valid;
  assign result.period_report   = res.period_report;
  assign result.width_report    = res.width_report;
  assign result.dead_flag       = res.dead_flag;
  assign result.capture_total   = res.capture_total;
  assign result.least_period    = res.least_period;
  assign result.greatest_period = res.greatest_period;
  assign result.least_width     = res.least_width;
  assign result.greatest_width  = res.greatest_width;
  assign result.stored_status   = res.stored_status;

endmodule

@@ sv/pwm_capture_monitor_core.sv @@
// Top level of the PWM capture monitor with loss-of-signal watchdog.
//
//   channel  dir  payload
//   -------  ---  ---------------------------------------------------------
//   item     in   cmd, period_us, width_us, capture_status, live_level
//   result   out  report_valid, period/width reports, dead_flag, totals,
//                 min/max trackers, stored_status
//   cfg      in   max_dead_count (always ready)
//
// One item per clock sustained while result.ready stays high. Each item passes
// through the input register and then the result register, from which its
// result can transfer out.
// A result waiting on result.ready holds the engine; the input register holds
// at most one more item, and item.ready stays low until that result transfers.
// Synchronous reset: watchdog starts dead, min trackers at 0xFFFF,
// max_dead_count at 5. Every item gives exactly one result.
module pwm_capture_monitor_core (
  input  logic      clk,
  input  logic      rst,
  pcm_in_if.sink    item,
  pcm_out_if.source result,
  pcm_cfg_if.sink   cfg
);
  import pcm_pkg::*;

  count_t max_dead_count;
  logic   held_valid;
  item_t  held;
  logic   take;

  // config register; the user must write it only while idle, the block does not enforce this
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_dead_count <= DEAD_COUNT_RESET;
    end else if (cfg.valid) begin
      max_dead_count <= cfg.max_dead_count;
    end
  end

  // input register
  pcm_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .take       (take),
    .held_valid (held_valid),
    .held       (held)
  );

  // state update and result register
  pcm_engine u_engine (
    .clk            (clk),
    .rst            (rst),
    .held_valid     (held_valid),
    .held           (held),
    .max_dead_count (max_dead_count),
    .take           (take),
    .result         (result)
  );

`ifndef SYNTHESIS
  // a live report never sets the dead bit of either word
  a_live_report_masked: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.report_valid && !result.dead_flag)
      |-> (result.period_report[15] == 1'b0 && result.width_report[15] == 1'b0))
    else $error("live report carries dead bit");

  // a dead report carries the dead word for the period
  a_dead_report_word: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.report_valid && result.dead_flag)
      |-> (result.period_report == DEAD_WORD))
    else $error("dead report period word wrong");

  // non-tick results carry zero report words
  a_no_report_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.report_valid)
      |-> (result.period_report == '0 && result.width_report == '0))
    else $error("report words set on non-tick result");

  // the engine never consumes an empty input register
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    take |-> held_valid)
    else $error("engine took without a held item");
`endif

endmodule

@@ bench/tb_pwm_capture_monitor_core.sv @@
// Self-checking testbench for pwm_capture_monitor_core: directed and random items against a predictor.
module tb_pwm_capture_monitor_core;
  import pcm_pkg::*;

  // Code 3 is not decoded by the block: it must leave all state alone.
  localparam cmd_code_t CMD_UNUSED = 2'd3;
  // Two-stage pipeline; the bench waits out spare cycles before a config write or the end.
  localparam int SETTLE_CYCLES = 4;
  localparam int STALL_PCT = 29;

  logic clk;
  logic rst;

  pcm_in_if  in_ch();
  pcm_out_if res_ch();
  pcm_cfg_if cfg_ch();

  pwm_capture_monitor_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Monitor predictor: own copy of the watchdog, trackers and dead-count setting.
  // ---------------------------------------------------------------------------
  typedef struct {
    word_t  held_period;
    word_t  held_width;
    word_t  held_status;
    word_t  total;          // wrapping capture count
    word_t  total_at_tick;  // capture count seen by the previous tick
    count_t idle_ticks;
    logic   dead;
    word_t  per_lo;
    word_t  per_hi;
    word_t  wid_lo;
    word_t  wid_hi;
  } monitor_state_t;

  monitor_state_t mon;
  count_t         dead_limit;
  result_t        pending_results[$];  // predicted results, oldest first
  int             error_count = 0;
  bit             steady = 0;          // 1: neither side idles

  function automatic void reset_monitor_model();
    mon.held_period   = '0;
    mon.held_width    = '0;
    mon.held_status   = '0;
    mon.total         = '0;
    mon.total_at_tick = '0;
    mon.idle_ticks    = '0;
    mon.dead          = 1'b1;  // watchdog starts out dead
    mon.per_lo        = WORD_MAX;
    mon.per_hi        = '0;
    mon.wid_lo        = WORD_MAX;
    mon.wid_hi        = '0;
    dead_limit        = DEAD_COUNT_RESET;
  endfunction

  function automatic result_t predict_result(item_t it);
    result_t r;
    r = '0;
    case (it.cmd)
      CMD_CAPTURE: begin
        mon.held_period = it.period_us;
        mon.held_width  = it.width_us;
        mon.held_status = it.capture_status;
        if (it.period_us > mon.per_hi) mon.per_hi = it.period_us;
        if (it.period_us < mon.per_lo) mon.per_lo = it.period_us;
        if (it.width_us > mon.wid_hi) mon.wid_hi = it.width_us;
        if (it.width_us < mon.wid_lo) mon.wid_lo = it.width_us;
        mon.total = mon.total + WORD_ONE;
      end
      CMD_TICK: begin
        // No capture since the last tick: climb toward the dead count. With a
        // dead count of zero the idle counter never climbs and dead holds.
        if (mon.total_at_tick == mon.total) begin
          if (mon.idle_ticks < dead_limit) begin
            mon.idle_ticks = mon.idle_ticks + COUNT_ONE;
            if (mon.idle_ticks >= dead_limit) mon.dead = 1'b1;
          end
        end else begin
          mon.dead       = 1'b0;
          mon.idle_ticks = '0;
        end
        mon.total_at_tick = mon.total;
        r.report_valid = 1'b1;
        if (!mon.dead) begin
          r.period_report = mon.held_period & MASK15;
          r.width_report  = mon.held_width & MASK15;
        end else begin
          r.period_report = DEAD_WORD;
          r.width_report  = it.live_level ? DEAD_WORD : '0;
        end
      end
      CMD_CLEAR: begin
        mon.per_lo = WORD_MAX;
        mon.per_hi = '0;
        mon.wid_lo = WORD_MAX;
        mon.wid_hi = '0;
      end
      default: ;  // unused code: status only
    endcase
    r.dead_flag       = mon.dead;
    r.capture_total   = mon.total;
    r.least_period    = mon.per_lo;
    r.greatest_period = mon.per_hi;
    r.least_width     = mon.wid_lo;
    r.greatest_width  = mon.wid_hi;
    r.stored_status   = mon.held_status;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and receiver side
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result ready drops about 29% of cycles unless in a steady stretch.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end
  end

  function automatic void check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      $error("%s: expected 0x%h, actual 0x%h", name, want, got);
      error_count++;
    end
  endfunction

  // Every result transfer is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with no prediction pending");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("report_valid", word_t'(want.report_valid),
                    word_t'(res_ch.report_valid));
        check_field("period_report", want.period_report, res_ch.period_report);
        check_field("width_report", want.width_report, res_ch.width_report);
        check_field("dead_flag", word_t'(want.dead_flag), word_t'(res_ch.dead_flag));
        check_field("capture_total", want.capture_total, res_ch.capture_total);
        check_field("least_period", want.least_period, res_ch.least_period);
        check_field("greatest_period", want.greatest_period, res_ch.greatest_period);
        check_field("least_width", want.least_width, res_ch.least_width);
        check_field("greatest_width", want.greatest_width, res_ch.greatest_width);
        check_field("stored_status", want.stored_status, res_ch.stored_status);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Valid stays high from one transfer into the next unless a gap is drawn,
  // so it is never lowered and raised in the same step.
  task automatic send_item(input item_t it);
    if (!steady) begin
      while ($urandom_range(99) < STALL_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= it.cmd;
    in_ch.period_us      <= it.period_us;
    in_ch.width_us       <= it.width_us;
    in_ch.capture_status <= it.capture_status;
    in_ch.live_level     <= it.live_level;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(predict_result(it));
  endtask

  // Lower valid and wait until every predicted result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_dead_count(input count_t limit);
    drain();
    cfg_ch.valid          <= 1'b1;
    cfg_ch.max_dead_count <= limit;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    dead_limit = limit;
  endtask

  // Bias toward the edges of the 16-bit range and the 15-bit report mask.
  function automatic word_t pick_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return WORD_MAX;
      2:       return MASK15;
      3:       return DEAD_WORD;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic item_t make_item(input cmd_code_t c);
    item_t it;
    it.cmd            = c;
    it.period_us      = pick_word();
    it.width_us       = pick_word();
    it.capture_status = pick_word();
    it.live_level     = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic item_t capture_item(input word_t per, input word_t wid,
                                         input word_t st);
    item_t it;
    it = make_item(CMD_CAPTURE);
    it.period_us      = per;
    it.width_us       = wid;
    it.capture_status = st;
    return it;
  endfunction

  function automatic item_t tick_item(input logic lvl);
    item_t it;
    it = make_item(CMD_TICK);
    it.live_level = lvl;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Out of reset: dead until a tick sees a capture, trackers at their limits.
  task automatic test_reset_state();
    send_item(tick_item(1'b0));
    send_item(tick_item(1'b1));
    send_item(make_item(CMD_UNUSED));
    send_item(capture_item(WORD_MAX, DEAD_WORD, WORD_MAX));
    send_item(capture_item('0, '0, '0));
    send_item(tick_item(1'b1));   // capture seen: live again
    send_item(make_item(CMD_CLEAR));
  endtask

  // Field extremes, masking of bit 15, clear and the unused code.
  task automatic test_field_extremes();
    write_dead_count(8'd2);
    send_item(capture_item(WORD_MAX, WORD_MAX, WORD_MAX));
    send_item(tick_item(1'b0));
    send_item(capture_item(DEAD_WORD, MASK15, DEAD_WORD));
    send_item(tick_item(1'b1));
    send_item(capture_item('0, '0, MASK15));
    send_item(make_item(CMD_UNUSED));
    send_item(make_item(CMD_CLEAR));
    send_item(tick_item(1'b0));
    send_item(tick_item(1'b1));   // first idle tick: still live at a count of two
    send_item(tick_item(1'b0));
    send_item(make_item(CMD_UNUSED));
  endtask

  // Dead count zero: idle ticks leave the dead mark as it is; a tick after a
  // capture still clears it. Then a dead count of one kills on the first idle tick.
  task automatic test_zero_dead_count();
    write_dead_count(8'd0);
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b0));
    send_item(capture_item(16'h1234, 16'h0567, 16'h00A5));
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b0));
    write_dead_count(8'd1);
    send_item(tick_item(1'b1));
    send_item(tick_item(1'b0));
  endtask

  // Largest dead count: needs 255 idle ticks in a row.
  task automatic test_longest_dead_count();
    write_dead_count(8'd255);
    send_item(make_item(CMD_CAPTURE));
    send_item(make_item(CMD_TICK));
    repeat (256) send_item(make_item(CMD_TICK));
    send_item(make_item(CMD_CAPTURE));
    send_item(make_item(CMD_TICK));
    send_item(make_item(CMD_TICK));
  endtask

  // Mixed traffic at one dead-count setting. Runs of back-to-back ticks push
  // the watchdog through its idle count into the dead state.
  task automatic test_random_phase(input count_t limit, input int n_items,
                                   input int tick_pct);
    int sent;
    int r;
    int run_len;
    write_dead_count(limit);
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 8) begin
        run_len = $urandom_range(int'(limit) + 2, 1);
        if (run_len > 24) run_len = 24;
        repeat (run_len) send_item(make_item(CMD_TICK));
        sent += run_len;
      end else begin
        r = $urandom_range(99);
        if (r < tick_pct) send_item(make_item(CMD_TICK));
        else if (r < tick_pct + 6) send_item(make_item(CMD_CLEAR));
        else if (r < tick_pct + 9) send_item(make_item(CMD_UNUSED));
        else send_item(make_item(CMD_CAPTURE));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst                   <= 1'b1;
    in_ch.valid           <= 1'b0;
    in_ch.cmd             <= CMD_CAPTURE;
    in_ch.period_us       <= '0;
    in_ch.width_us        <= '0;
    in_ch.capture_status  <= '0;
    in_ch.live_level      <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.max_dead_count <= '0;
    reset_monitor_model();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_field_extremes();
    test_zero_dead_count();

    steady = 1;  // one long stretch with no idling on either side
    test_random_phase(8'd3, 100, 40);
    steady = 0;
    test_random_phase(8'd0, 100, 45);
    test_random_phase(8'd1, 100, 45);
    test_random_phase(8'd2, 100, 50);
    test_random_phase(DEAD_COUNT_RESET, 120, 55);
    test_random_phase(8'd8, 100, 60);
    test_random_phase(count_t'($urandom_range(12, 2)), 100, 50);
    test_longest_dead_count();

    drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("pwm_capture_monitor_core test passed");
    end else begin
      $display("pwm_capture_monitor_core test failed");
    end
    $finish;
  end

  // Run limit: far beyond the slowest correct run.
  initial begin
    #80_000_000;
    $display("pwm_capture_monitor_core test failed");
    $finish;
  end

endmodule

@@ pwm_capture_monitor_core.f @@
sv/pcm_pkg.sv
sv/pcm_if.sv
sv/pcm_in_reg.sv
sv/pcm_engine.sv
sv/pwm_capture_monitor_core.sv
bench/tb_pwm_capture_monitor_core.sv
